@@ design/spr_pkg.sv @@
// Package for the SLIP packet receiver: framing codes, packet types, size table, result type.
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

	// Default frame buffer size in bytes
	localparam int BUFFER_BYTES_DEF = 32;

	// SLIP framing codes
	localparam logic [7:0] SLIP_END     = 8'hC0;
	localparam logic [7:0] SLIP_ESC     = 8'hDB;
	localparam logic [7:0] SLIP_ESC_END = 8'hDC;
	localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

	// Number of packet types and the longest valid frame (calibration)
	localparam int          TYPE_COUNT  = 17;
	localparam int          STORE_BYTES = 25;
	localparam int          STORE_IDX_W = $clog2(STORE_BYTES);
	localparam int          TYPE_W      = 5;
	localparam int          SIZE_W      = 5;
	localparam int          CAL_WORDS   = 6;

	// Packet type codes that carry a payload
	localparam logic [TYPE_W-1:0] TYPE_COLOR  = 5'd6;
	localparam logic [TYPE_W-1:0] TYPE_BLINK  = 5'd7;
	localparam logic [TYPE_W-1:0] TYPE_IR     = 5'd8;
	localparam logic [TYPE_W-1:0] TYPE_STREAM = 5'd9;
	localparam logic [TYPE_W-1:0] TYPE_CALIB  = 5'd12;
	localparam logic [TYPE_W-1:0] TYPE_DDR    = 5'd13;
	localparam logic [TYPE_W-1:0] TYPE_PORT   = 5'd14;
	localparam logic [TYPE_W-1:0] TYPE_POWER  = 5'd15;

	// Bytes of the current frame that can take part in a valid packet
	typedef logic [STORE_BYTES-1:0][7:0] frame_bytes_t;

	// One decoded packet
	typedef struct packed {
		logic [TYPE_W-1:0]           packet_type;
		logic [7:0]                  color_0;
		logic [7:0]                  color_1;
		logic [7:0]                  color_2;
		logic [7:0]                  port_bits;
		logic [CAL_WORDS-1:0][31:0]  cal_word;
	} result_t;

	// Exact frame length, type byte included, for each packet type
	function automatic logic [SIZE_W-1:0] type_size(input logic [TYPE_W-1:0] kind);
		logic [SIZE_W-1:0] size;
		unique case (kind) inside
			TYPE_COLOR, TYPE_BLINK:                        size = 5'd4;
			TYPE_IR, TYPE_STREAM, TYPE_DDR, TYPE_PORT,
			TYPE_POWER:                                    size = 5'd2;
			TYPE_CALIB:                                    size = 5'd25;
			default:                                       size = 5'd1;
		endcase
		return size;
	endfunction

endpackage

`default_nettype wire

@@ design/spr_deframer.sv @@
// SLIP deframer: escape flag, frame length counter and frame byte store.
`timescale 1ns / 1ps
`default_nettype none

module spr_deframer
	import spr_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	localparam int LEN_W       = $clog2(BUFFER_BYTES + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       rx_byte,
	output logic                  frame_end,
	output logic [LEN_W-1:0]      frame_len,
	output frame_bytes_t          frame_bytes
);

	logic              escape_q;
	logic [LEN_W-1:0]  len_q;
	frame_bytes_t      store_q;
	logic              is_end;
	logic              is_esc;
	logic [7:0]        data_byte;

	// Classify the incoming word and undo escaping
	always_comb begin
		is_end    = (rx_byte == SLIP_END);
		is_esc    = (rx_byte == SLIP_ESC);
		data_byte = rx_byte;
		if (escape_q && rx_byte == SLIP_ESC_END) begin
			data_byte = SLIP_END;
		end else if (escape_q && rx_byte == SLIP_ESC_ESC) begin
			data_byte = SLIP_ESC;
		end
	end

	// Advance escape flag and length; drop the frame on END or overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b0;
			len_q    <= '0;
		end else if (accept) begin
			escape_q <= is_esc;
			if (is_end) begin
				len_q <= '0;
			end else if (!is_esc) begin
				if (len_q == LEN_W'(BUFFER_BYTES)) begin
					len_q <= '0;
				end else begin
					len_q <= len_q + 1'b1;
				end
			end
		end
	end

	// Hold only the bytes a valid packet can use
	always_ff @(posedge clk) begin
		if (accept && !is_end && !is_esc && len_q < LEN_W'(STORE_BYTES)) begin
			store_q[len_q[STORE_IDX_W-1:0]] <= data_byte;
		end
	end

	assign frame_end   = accept && is_end;
	assign frame_len   = len_q;
	assign frame_bytes = store_q;

endmodule

`default_nettype wire

@@ design/spr_frame_check.sv @@
// Frame check: validates type and length of a closed frame and extracts its payload.
`timescale 1ns / 1ps
`default_nettype none

module spr_frame_check
	import spr_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	localparam int LEN_W       = $clog2(BUFFER_BYTES + 1)
) (
	input  wire logic             frame_end,
	input  wire logic [LEN_W-1:0] frame_len,
	input  wire frame_bytes_t     frame_bytes,
	output logic                  pkt_valid,
	output result_t               pkt
);

	logic [7:0]        kind_byte;
	logic [TYPE_W-1:0] kind;
	logic              type_ok;

	assign kind_byte = frame_bytes[0];
	assign kind      = kind_byte[TYPE_W-1:0];
	assign type_ok   = kind_byte < 8'(TYPE_COUNT);

	// Accept only a non-empty frame of the exact size for its type
	assign pkt_valid = frame_end && (frame_len != '0) && type_ok &&
		(frame_len == LEN_W'(type_size(kind)));

	// Pick the payload fields this type sets; zero the rest
	always_comb begin
		pkt             = '0;
		pkt.packet_type = kind;
		case (kind) inside
			TYPE_COLOR, TYPE_BLINK: begin
				pkt.color_0 = frame_bytes[1];
				pkt.color_1 = frame_bytes[2];
				pkt.color_2 = frame_bytes[3];
			end
			TYPE_IR, TYPE_STREAM, TYPE_DDR, TYPE_PORT, TYPE_POWER: begin
				pkt.port_bits = frame_bytes[1];
			end
			TYPE_CALIB: begin
				for (int j = 0; j < CAL_WORDS; j++) begin
					pkt.cal_word[j] = {frame_bytes[1 + 4 * j], frame_bytes[2 + 4 * j],
						frame_bytes[3 + 4 * j], frame_bytes[4 + 4 * j]};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ design/spr_out_buf.sv @@
// Result register with a skid stage between the frame check and the output channel.
`timescale 1ns / 1ps
`default_nettype none

module spr_out_buf
	import spr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         full,
	output logic         out_valid,
	input  wire logic    out_stall,
	output result_t      out_data
);

	logic    main_v_q;
	logic    skid_v_q;
	result_t main_q;
	result_t skid_q;
	logic    take;

	assign take = main_v_q && !out_stall;

	// Track occupancy of result and skid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			if (main_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end
	end

	// Move payload: refill from skid first, else load the new word
	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_v_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_v_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

endmodule

`default_nettype wire

@@ design/slip_packet_receiver.sv @@
// Top level of the SLIP packet receiver: deframer, frame check and result buffer.
//
//  channel | signals                          | direction | word
//  --------+----------------------------------+-----------+------------------------------
//  in      | in_valid, in_stall, rx_byte      | into      | one raw serial byte
//  out     | out_valid, out_stall, packet_*   | out of    | one decoded packet
//
// One byte is taken every cycle while in_stall is low. A valid packet closed by a taken END
// byte is registered in the result register, or in the skid register if the result one is full.
// The frame check is a single combinational pass over the stored frame bytes. in_stall
// rises only when both result and skid registers hold a packet. Reset clears the escape
// flag, the length and the output valid bits; the frame byte store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module slip_packet_receiver
	import spr_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	localparam int LEN_W       = $clog2(BUFFER_BYTES + 1)
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [4:0]       packet_type,
	output logic [7:0]       color_0,
	output logic [7:0]       color_1,
	output logic [7:0]       color_2,
	output logic [7:0]       port_bits,
	output logic [31:0]      cal_word_0,
	output logic [31:0]      cal_word_1,
	output logic [31:0]      cal_word_2,
	output logic [31:0]      cal_word_3,
	output logic [31:0]      cal_word_4,
	output logic [31:0]      cal_word_5
);

	logic             accept;
	logic             frame_end;
	logic [LEN_W-1:0] frame_len;
	frame_bytes_t     frame_bytes;
	logic             pkt_valid;
	result_t          pkt;
	logic             buf_full;
	result_t          out_data;

	assign accept   = in_valid && !in_stall;
	assign in_stall = buf_full;

	spr_deframer #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_deframer (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (rx_byte),
		.frame_end   (frame_end),
		.frame_len   (frame_len),
		.frame_bytes (frame_bytes)
	);

	spr_frame_check #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_frame_check (
		.frame_end   (frame_end),
		.frame_len   (frame_len),
		.frame_bytes (frame_bytes),
		.pkt_valid   (pkt_valid),
		.pkt         (pkt)
	);

	spr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pkt_valid),
		.push_data (pkt),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// Fan the packet out to its ports
	assign packet_type = out_data.packet_type;
	assign color_0     = out_data.color_0;
	assign color_1     = out_data.color_1;
	assign color_2     = out_data.color_2;
	assign port_bits   = out_data.port_bits;
	assign cal_word_0  = out_data.cal_word[0];
	assign cal_word_1  = out_data.cal_word[1];
	assign cal_word_2  = out_data.cal_word[2];
	assign cal_word_3  = out_data.cal_word[3];
	assign cal_word_4  = out_data.cal_word[4];
	assign cal_word_5  = out_data.cal_word[5];

endmodule

`default_nettype wire
